// ===== rtl/core/ikvs_pkg.sv =====
package ikvs_pkg;

   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 5;

   localparam logic [1:0] REG_KEY_CHARS_LOW  = 2'd0;
   localparam logic [1:0] REG_KEY_CHARS_HIGH = 2'd1;
   localparam logic [1:0] REG_KEY_LENGTH     = 2'd2;

   localparam logic [1:0] KIND_VALUE     = 2'd0;
   localparam logic [1:0] KIND_FOUND     = 2'd1;
   localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;

   typedef struct packed {
      logic [127:0] chars;
      logic [4:0]   length;
   } key_cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  value_byte;
      logic [15:0] value_length;
      logic        final_res;
   } result_type;

endpackage

// ===== rtl/core/ikvs_csr.sv =====
module ikvs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ikvs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ikvs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ikvs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output ikvs_pkg::key_cfg_type              key_cfg
);
   import ikvs_pkg::*;

   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic [4:0]  key_length_ff;
   logic        wr_en;
   logic [1:0]  reg_index;

   assign reg_index  = csr_paddr[4:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         key_length_ff <= '0;
      end else if (wr_en) begin
         case (reg_index)
            REG_KEY_CHARS_LOW: begin
               key_low_ff <= csr_pwdata;
            end
            REG_KEY_CHARS_HIGH: begin
               key_high_ff <= csr_pwdata;
            end
            REG_KEY_LENGTH: begin
               key_length_ff <= csr_pwdata[4:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_KEY_CHARS_LOW:  csr_prdata = key_low_ff;
         REG_KEY_CHARS_HIGH: csr_prdata = key_high_ff;
         REG_KEY_LENGTH:     csr_prdata = {59'd0, key_length_ff};
         default:            csr_prdata = '0;
      endcase
   end

   assign key_cfg.chars  = {key_high_ff, key_low_ff};
   assign key_cfg.length = key_length_ff;

endmodule

// ===== rtl/core/ikvs_core.sv =====
module ikvs_core #(
   parameter int unsigned MAX_KEY_CHARS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ikvs_pkg::key_cfg_type key_cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_text_byte,
   input  logic                  req_first_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ikvs_pkg::result_type  rsp_result
);
   import ikvs_pkg::*;

   typedef enum logic [2:0] {
      PH_LINE_START = 3'd0,
      PH_SKIP_LINE  = 3'd1,
      PH_MATCH      = 3'd2,
      PH_FIND_EQ    = 3'd3,
      PH_PRE_VALUE  = 3'd4,
      PH_VALUE      = 3'd5,
      PH_DONE       = 3'd6
   } phase_type;

   localparam logic [4:0] MAX_LEN = 5'(MAX_KEY_CHARS);

   function automatic logic [7:0] fold(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'd32;
      end
      return c;
   endfunction

   logic        s1_valid_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_first_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;
   phase_type   phase_ff;
   logic [4:0]  mp_ff;
   logic [15:0] raw_ff;
   logic [15:0] trim_ff;

   phase_type   phase_in;
   logic [4:0]  mp_in;
   logic [15:0] raw_in;
   logic [15:0] trim_in;
   phase_type   cur_phase;
   logic [4:0]  cur_mp;
   logic [15:0] cur_raw;
   logic [15:0] cur_trim;
   logic [4:0]  key_len;
   logic [4:0]  match_mp;
   logic [7:0]  key_byte;
   logic [7:0]  b;
   logic        is_eol;
   logic        do_match;
   logic        do_skip;
   logic        do_find_eq;
   logic        hit_nf;
   logic        hit_found;
   logic        hit_value;
   logic        hit;
   result_type  res;
   logic        advance;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign b         = s1_byte_ff;
   assign is_eol    = (b == CHAR_LF) || (b == CHAR_CR);
   assign key_len   = (key_cfg.length > MAX_LEN) ? MAX_LEN : key_cfg.length;

   always_comb begin
      cur_phase  = s1_first_ff ? PH_LINE_START : phase_ff;
      cur_mp     = s1_first_ff ? 5'd0 : mp_ff;
      cur_raw    = s1_first_ff ? 16'd0 : raw_ff;
      cur_trim   = s1_first_ff ? 16'd0 : trim_ff;
      phase_in   = cur_phase;
      mp_in      = cur_mp;
      raw_in     = cur_raw;
      trim_in    = cur_trim;
      match_mp   = cur_mp;
      do_match   = 1'b0;
      do_skip    = 1'b0;
      do_find_eq = 1'b0;
      hit_nf     = 1'b0;
      hit_found  = 1'b0;
      hit_value  = 1'b0;
      key_byte   = '0;

      if (cur_phase == PH_DONE) begin
      end else if (key_len == 5'd0) begin
         hit_nf = 1'b1;
      end else begin
         case (cur_phase)
            PH_LINE_START: begin
               if (b == CHAR_NUL) begin
                  hit_nf = 1'b1;
               end else if (b <= CHAR_SPACE) begin
               end else if (b == CHAR_SEMI) begin
                  phase_in = PH_SKIP_LINE;
               end else begin
                  do_match = 1'b1;
                  match_mp = 5'd0;
                  mp_in    = 5'd0;
               end
            end
            PH_MATCH: begin
               do_match = 1'b1;
            end
            PH_SKIP_LINE: begin
               do_skip = 1'b1;
            end
            PH_FIND_EQ: begin
               do_find_eq = 1'b1;
            end
            PH_PRE_VALUE: begin
               if (b == CHAR_NUL || is_eol) begin
                  trim_in   = 16'd0;
                  hit_found = 1'b1;
               end else if (b > CHAR_SPACE) begin
                  phase_in  = PH_VALUE;
                  raw_in    = 16'd1;
                  trim_in   = 16'd1;
                  hit_value = 1'b1;
               end
            end
            PH_VALUE: begin
               if (b < CHAR_SPACE) begin
                  hit_found = 1'b1;
               end else begin
                  if (cur_raw != 16'hFFFF) begin
                     raw_in = cur_raw + 16'd1;
                  end
                  if (b != CHAR_SPACE) begin
                     trim_in = raw_in;
                  end
                  hit_value = 1'b1;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase

         if (do_match) begin
            key_byte = key_cfg.chars[{match_mp[3:0], 3'b000} +: 8];
            if (b == CHAR_NUL) begin
               hit_nf = 1'b1;
            end else if (match_mp < key_len) begin
               if (fold(b) == fold(key_byte)) begin
                  mp_in    = match_mp + 5'd1;
                  phase_in = PH_MATCH;
               end else begin
                  do_skip = 1'b1;
               end
            end else if (b == CHAR_EQ) begin
               phase_in = PH_PRE_VALUE;
            end else if (b <= CHAR_SPACE) begin
               do_find_eq = 1'b1;
            end else begin
               do_skip = 1'b1;
            end
         end

         if (do_skip) begin
            if (b == CHAR_NUL) begin
               hit_nf = 1'b1;
            end else begin
               phase_in = is_eol ? PH_LINE_START : PH_SKIP_LINE;
            end
         end

         if (do_find_eq) begin
            if (b == CHAR_NUL) begin
               hit_nf = 1'b1;
            end else if (b == CHAR_EQ) begin
               phase_in = PH_PRE_VALUE;
            end else if (is_eol) begin
               phase_in = PH_LINE_START;
            end else begin
               phase_in = PH_FIND_EQ;
            end
         end
      end

      res = '0;
      if (hit_nf) begin
         phase_in      = PH_DONE;
         res.kind      = KIND_NOT_FOUND;
         res.final_res = 1'b1;
      end else if (hit_found) begin
         phase_in         = PH_DONE;
         res.kind         = KIND_FOUND;
         res.value_length = trim_in;
         res.final_res    = 1'b1;
      end else if (hit_value) begin
         res.kind       = KIND_VALUE;
         res.value_byte = b;
      end
      hit = hit_nf || hit_found || hit_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_LINE_START;
         mp_ff        <= '0;
         raw_ff       <= '0;
         trim_ff      <= '0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         if (req_valid) begin
            s1_byte_ff  <= req_text_byte;
            s1_first_ff <= req_first_byte;
         end
         rsp_valid_ff <= s1_valid_ff && hit;
         if (s1_valid_ff) begin
            phase_ff <= phase_in;
            mp_ff    <= mp_in;
            raw_ff   <= raw_in;
            trim_ff  <= trim_in;
            if (hit) begin
               rsp_ff <= res;
            end
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

// ===== rtl/core/ini_key_value_scanner_unit.sv =====
// INI key lookup over a byte stream. Each accepted beat carries one text byte; the block
// looks for the first line whose leading non-blank characters equal the key held in the
// csr registers (ASCII letters compared without case, ';' lines skipped), then streams the
// value bytes out one result beat each and closes with a found beat that carries the
// trimmed value length, or a not-found beat. Raise req_first_byte to start a new text. One
// byte is taken every clock cycle while the input is not stalled: a byte goes from the
// input register through the scan logic into the result register, where its result beat
// is offered, and the input only stalls while the result register is full and rsp_stall
// holds it. After the done beat, further bytes give no result until the next first byte.
// Write the key registers only while the block is idle.
module ini_key_value_scanner_unit #(
   parameter int unsigned MAX_KEY_CHARS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_text_byte,
   input  logic                            req_first_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic [7:0]                      rsp_value_byte,
   output logic [15:0]                     rsp_value_length,
   output logic                            rsp_final_res,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ikvs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ikvs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ikvs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import ikvs_pkg::*;

   key_cfg_type key_cfg;
   result_type  rsp_result;

   ikvs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key_cfg     (key_cfg)
   );

   ikvs_core #(
      .MAX_KEY_CHARS (MAX_KEY_CHARS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .key_cfg        (key_cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_first_byte (req_first_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result     (rsp_result)
   );

   assign rsp_kind         = rsp_result.kind;
   assign rsp_value_byte   = rsp_result.value_byte;
   assign rsp_value_length = rsp_result.value_length;
   assign rsp_final_res    = rsp_result.final_res;

endmodule

// ===== rtl/core/ikvs_checker.sv =====
module ikvs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_value_byte,
   input logic [15:0] rsp_value_length,
   input logic        rsp_final_res
);
   import ikvs_pkg::*;

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value_byte)
         && $stable(rsp_value_length) && $stable(rsp_final_res))
      else $error("stalled result beat changed");

   // input only backs up behind a stalled output
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output free");

   // a result beat appears only in answer to an accepted byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result beat without a byte");

   // done beats carry a done kind and value beats carry no length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_final_res && (rsp_kind == KIND_FOUND || rsp_kind == KIND_NOT_FOUND))
         || (!rsp_final_res && rsp_kind == KIND_VALUE && rsp_value_length == 16'd0))
      else $error("inconsistent result beat");

endmodule

bind ini_key_value_scanner_unit ikvs_checker u_ikvs_checker (.*);

// ===== bench/ini_key_value_scanner_unit_test.sv =====
`timescale 1ns / 1ps

module ini_key_value_scanner_unit_test;
   import ikvs_pkg::*;

   localparam int unsigned TARGET_BEATS = 1350;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned DIRECTED_COUNT = 27;

   localparam logic [7:0] CHAR_TAB = 8'h09;

   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_CSR  = 2'd1;

   localparam logic [1:0] CHK_PRED = 2'd0;
   localparam logic [1:0] CHK_RES  = 2'd1;
   localparam logic [1:0] CHK_NONE = 2'd2;

   typedef enum logic [2:0] {
      SCAN_LINE_START,
      SCAN_SKIP_LINE,
      SCAN_KEY,
      SCAN_FIND_EQ,
      SCAN_PRE_VALUE,
      SCAN_VALUE,
      SCAN_DONE
   } scan_phase_type;

   typedef struct packed {
      logic [1:0]  act;
      logic [1:0]  chk;
      logic [1:0]  reg_idx;
      logic [63:0] data;
      logic [7:0]  text;
      logic        first;
      result_type  res;
   } stim_row_type;

   localparam result_type NO_RESULT = '0;
   localparam result_type RES_NOT_FOUND = '{KIND_NOT_FOUND, 8'h00, 16'd0, 1'b1};
   localparam logic [63:0] KEY_WORD = 64'h0000_0000_0079_456B;

   localparam stim_row_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      '{ACT_BYTE, CHK_RES,  REG_KEY_CHARS_LOW,  64'd0, "x", 1'b1, RES_NOT_FOUND},
      '{ACT_BYTE, CHK_NONE, REG_KEY_CHARS_LOW,  64'd0, "y", 1'b0, NO_RESULT},
      '{ACT_CSR,  CHK_NONE, REG_KEY_CHARS_LOW,  KEY_WORD, 8'h00, 1'b0, NO_RESULT},
      '{ACT_CSR,  CHK_NONE, REG_KEY_CHARS_HIGH, '1,    8'h00, 1'b0, NO_RESULT},
      '{ACT_CSR,  CHK_NONE, REG_KEY_LENGTH,     64'd3, 8'h00, 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, " ", 1'b1, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, ";", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, "K", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, CHAR_LF, 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, "k", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, "e", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, "Y", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, "x", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, CHAR_CR, 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, "K", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, "E", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, "Y", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, " ", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, "z", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, "=", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, " ", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_RES,  REG_KEY_CHARS_LOW,  64'd0, 8'hFF, 1'b0,
        '{KIND_VALUE, 8'hFF, 16'd0, 1'b0}},
      '{ACT_BYTE, CHK_RES,  REG_KEY_CHARS_LOW,  64'd0, " ", 1'b0,
        '{KIND_VALUE, 8'h20, 16'd0, 1'b0}},
      '{ACT_BYTE, CHK_RES,  REG_KEY_CHARS_LOW,  64'd0, 8'h1F, 1'b0,
        '{KIND_FOUND, 8'h00, 16'd1, 1'b1}},
      '{ACT_BYTE, CHK_NONE, REG_KEY_CHARS_LOW,  64'd0, "a", 1'b0, NO_RESULT},
      '{ACT_BYTE, CHK_PRED, REG_KEY_CHARS_LOW,  64'd0, "k", 1'b1, NO_RESULT},
      '{ACT_BYTE, CHK_RES,  REG_KEY_CHARS_LOW,  64'd0, CHAR_NUL, 1'b0, RES_NOT_FOUND}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_text_byte;
   logic                  req_first_byte;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_kind;
   logic [7:0]            rsp_value_byte;
   logic [15:0]           rsp_value_length;
   logic                  rsp_final_res;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [63:0] key_lo = '0;
   logic [63:0] key_hi = '0;
   logic [4:0]  key_len = '0;
   scan_phase_type scan_ph = SCAN_LINE_START;
   int unsigned key_pos = 0;
   logic [15:0] raw_len = '0;
   logic [15:0] trim_len = '0;

   result_type  pending_results [$];
   logic [7:0]  text_q [$];
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned beats_sent = 0;
   int unsigned mismatches = 0;

   ini_key_value_scanner_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_first_byte   (req_first_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_value_byte   (rsp_value_byte),
      .rsp_value_length (rsp_value_length),
      .rsp_final_res    (rsp_final_res),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic logic [7:0] key_byte(input int unsigned idx);
      logic [127:0] chars;
      chars = {key_hi, key_lo};
      return chars[8*idx +: 8];
   endfunction

   function automatic int unsigned active_key_len();
      return (key_len > 5'd16) ? 16 : int'(key_len);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic void close_scan(input logic [1:0] kind, output result_type r);
      scan_ph = SCAN_DONE;
      r = '0;
      r.kind = kind;
      r.value_length = (kind == KIND_FOUND) ? trim_len : 16'd0;
      r.final_res = 1'b1;
   endfunction

   function automatic logic line_end(input logic [7:0] b);
      return b == CHAR_LF || b == CHAR_CR;
   endfunction

   // one text beat through the scanner, returns 1 when it yields a result beat
   function automatic logic scan_byte(input logic [7:0] b, input logic first,
                                      output result_type r);
      int unsigned klen;
      r = '0;
      if (first) begin
         scan_ph = SCAN_LINE_START;
         key_pos = 0;
         raw_len = '0;
         trim_len = '0;
      end
      if (scan_ph == SCAN_DONE) return 1'b0;
      klen = active_key_len();
      if (klen == 0) begin
         close_scan(KIND_NOT_FOUND, r);
         return 1'b1;
      end
      if (scan_ph == SCAN_LINE_START) begin
         if (b == CHAR_NUL) begin
            close_scan(KIND_NOT_FOUND, r);
            return 1'b1;
         end
         if (b <= CHAR_SPACE) return 1'b0;
         if (b == CHAR_SEMI) begin
            scan_ph = SCAN_SKIP_LINE;
            return 1'b0;
         end
         key_pos = 0;
         scan_ph = SCAN_KEY;
      end
      case (scan_ph)
         SCAN_KEY: begin
            if (b == CHAR_NUL) begin
               close_scan(KIND_NOT_FOUND, r);
               return 1'b1;
            end
            if (key_pos < klen) begin
               if (to_lower(b) == to_lower(key_byte(key_pos))) key_pos++;
               else scan_ph = line_end(b) ? SCAN_LINE_START : SCAN_SKIP_LINE;
            end else if (b == CHAR_EQ) begin
               scan_ph = SCAN_PRE_VALUE;
            end else if (b <= CHAR_SPACE) begin
               scan_ph = line_end(b) ? SCAN_LINE_START : SCAN_FIND_EQ;
            end else begin
               scan_ph = SCAN_SKIP_LINE;
            end
            return 1'b0;
         end
         SCAN_SKIP_LINE: begin
            if (b == CHAR_NUL) begin
               close_scan(KIND_NOT_FOUND, r);
               return 1'b1;
            end
            if (line_end(b)) scan_ph = SCAN_LINE_START;
            return 1'b0;
         end
         SCAN_FIND_EQ: begin
            if (b == CHAR_NUL) begin
               close_scan(KIND_NOT_FOUND, r);
               return 1'b1;
            end
            if (b == CHAR_EQ) scan_ph = SCAN_PRE_VALUE;
            else if (line_end(b)) scan_ph = SCAN_LINE_START;
            return 1'b0;
         end
         SCAN_PRE_VALUE: begin
            if (b == CHAR_NUL || line_end(b)) begin
               trim_len = '0;
               close_scan(KIND_FOUND, r);
               return 1'b1;
            end
            if (b <= CHAR_SPACE) return 1'b0;
            scan_ph = SCAN_VALUE;
            raw_len = 16'd1;
            trim_len = 16'd1;
            r.kind = KIND_VALUE;
            r.value_byte = b;
            return 1'b1;
         end
         SCAN_VALUE: begin
            if (b < CHAR_SPACE) begin
               close_scan(KIND_FOUND, r);
               return 1'b1;
            end
            if (raw_len != 16'hFFFF) raw_len++;
            if (b != CHAR_SPACE) trim_len = raw_len;
            r.kind = KIND_VALUE;
            r.value_byte = b;
            return 1'b1;
         end
         default: begin
            scan_ph = SCAN_DONE;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic first, input logic [1:0] chk,
                            input result_type typed);
      result_type r;
      logic has_res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_first_byte <= first;
      do @(posedge clock); while (req_stall !== 1'b0);
      has_res = scan_byte(b, first, r);
      if (chk == CHK_RES) pending_results.push_back(typed);
      else if (chk == CHK_PRED && has_res) pending_results.push_back(r);
      beats_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      wait_idle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_KEY_CHARS_LOW:  key_lo = value;
         REG_KEY_CHARS_HIGH: key_hi = value;
         REG_KEY_LENGTH:     key_len = value[4:0];
         default: ;
      endcase
   endtask

   function automatic logic [7:0] word_char();
      case ($urandom_range(2))
         0:       return 8'("a" + $urandom_range(25));
         1:       return 8'("A" + $urandom_range(25));
         default: return 8'("0" + $urandom_range(9));
      endcase
   endfunction

   function automatic logic [7:0] case_flip(input logic [7:0] c);
      if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(1) == 0)
         return c ^ 8'h20;
      return c;
   endfunction

   task automatic pick_key();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0] n;
      int i;
      case ($urandom_range(9))
         0:       n = 5'd0;
         1:       n = 5'd16;
         2:       n = 5'd1;
         default: n = 5'($urandom_range(8, 2));
      endcase
      if ($urandom_range(3) == 0) begin
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
      end else begin
         for (i = 0; i < 8; i++) begin
            lo[8*i +: 8] = word_char();
            hi[8*i +: 8] = word_char();
         end
      end
      csr_write(REG_KEY_CHARS_LOW, lo);
      csr_write(REG_KEY_CHARS_HIGH, hi);
      csr_write(REG_KEY_LENGTH, {59'd0, n});
   endtask

   task automatic add_blanks(input int unsigned most);
      repeat ($urandom_range(most))
         text_q.push_back(($urandom_range(1) == 0) ? CHAR_SPACE : CHAR_TAB);
   endtask

   task automatic add_word(input int unsigned most);
      repeat ($urandom_range(most, 1)) text_q.push_back(word_char());
   endtask

   task automatic add_key(input int unsigned n);
      int unsigned i;
      logic [7:0] c;
      for (i = 0; i < n; i++) begin
         c = key_byte(i);
         if ($urandom_range(15) == 0) c = word_char();
         text_q.push_back(case_flip(c));
      end
   endtask

   task automatic add_value();
      add_blanks(2);
      repeat ($urandom_range(6)) text_q.push_back(8'($urandom_range(255, 32)));
      repeat ($urandom_range(2)) text_q.push_back(CHAR_SPACE);
   endtask

   task automatic build_text();
      int unsigned lines;
      int unsigned i;
      int unsigned klen;
      text_q.delete();
      klen = active_key_len();
      lines = $urandom_range(4, 1);
      for (i = 0; i < lines; i++) begin
         add_blanks(2);
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               add_key(klen);
               case ($urandom_range(3))
                  0: text_q.push_back(CHAR_EQ);
                  1: begin
                     text_q.push_back(CHAR_SPACE);
                     add_word(3);
                     text_q.push_back(CHAR_EQ);
                  end
                  2: begin
                     add_word(2);
                     text_q.push_back(CHAR_EQ);
                  end
                  default: begin
                     add_blanks(2);
                     add_word(3);
                  end
               endcase
               add_value();
            end
            4: begin
               text_q.push_back(CHAR_SEMI);
               add_value();
            end
            5: begin
               add_key($urandom_range(klen));
               text_q.push_back(CHAR_EQ);
               add_value();
            end
            6: begin
               add_word(5);
               text_q.push_back(CHAR_EQ);
               add_value();
            end
            7: ;
            default: begin
               repeat ($urandom_range(6)) text_q.push_back(8'($urandom_range(255, 1)));
            end
         endcase
         if (i + 1 < lines || $urandom_range(3) != 0) begin
            case ($urandom_range(2))
               0: text_q.push_back(CHAR_LF);
               1: text_q.push_back(CHAR_CR);
               default: begin
                  text_q.push_back(CHAR_CR);
                  text_q.push_back(CHAR_LF);
               end
            endcase
         end
      end
      if ($urandom_range(7) != 0) text_q.push_back(CHAR_NUL);
   endtask

   task automatic send_text();
      int k;
      for (k = 0; k < text_q.size(); k++) send_byte(text_q[k], k == 0, CHK_PRED, NO_RESULT);
   endtask

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result beat: kind %0d byte %0h", rsp_kind, rsp_value_byte);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               mismatches++;
            end
            if (rsp_value_byte !== want.value_byte) begin
               $error("value_byte: expected %0h, got %0h", want.value_byte, rsp_value_byte);
               mismatches++;
            end
            if (rsp_value_length !== want.value_length) begin
               $error("value_length: expected %0d, got %0d", want.value_length,
                      rsp_value_length);
               mismatches++;
            end
            if (rsp_final_res !== want.final_res) begin
               $error("final_res: expected %0d, got %0d", want.final_res, rsp_final_res);
               mismatches++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      int unsigned i;
      int unsigned phase_no;
      reset = 1'b1;
      req_valid = 1'b0;
      req_text_byte = '0;
      req_first_byte = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_COUNT; i++) begin
         if (DIRECTED_ROWS[i].act == ACT_CSR)
            csr_write(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].data);
         else
            send_byte(DIRECTED_ROWS[i].text, DIRECTED_ROWS[i].first, DIRECTED_ROWS[i].chk,
                      DIRECTED_ROWS[i].res);
      end

      for (phase_no = 0; beats_sent < TARGET_BEATS; phase_no++) begin
         case (phase_no % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 57;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 57;
            end
            default: begin
               send_idle_pct = 16;
               stall_pct = 16;
            end
         endcase
         pick_key();
         repeat ($urandom_range(12, 6)) begin
            if (beats_sent < TARGET_BEATS) begin
               if ($urandom_range(7) == 0) begin
                  repeat ($urandom_range(8, 1))
                     send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), CHK_PRED,
                               NO_RESULT);
               end else begin
                  build_text();
                  send_text();
               end
            end
         end
      end

      wait_idle();
      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ikvs_pkg.sv
rtl/core/ikvs_csr.sv
rtl/core/ikvs_core.sv
rtl/core/ini_key_value_scanner_unit.sv
rtl/core/ikvs_checker.sv
bench/ini_key_value_scanner_unit_test.sv
